// ===== src/rasi_pkg.sv =====
// ----------------------------------------------------------------------------
// rasi_pkg
// Shared types, widths and helpers of the ray versus box slab test pipeline.
// ----------------------------------------------------------------------------
package rasi_pkg;

    // Fixed-point format of all coordinates
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;       // bound - origin
    localparam int MAG_W      = COORD_W;           // |direction|
    localparam int QBITS      = COORD_W + 1;       // quotient bits kept
    localparam int DIV_STAGES = QBITS;             // one quotient bit a stage
    localparam int THR_W      = 17;
    localparam int T_W        = 31;
    localparam int NUM_AXES   = 3;
    localparam int NUM_JOBS   = 2 * NUM_AXES;      // lo and hi per axis

    localparam logic signed [COORD_W-1:0] T_INF = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] T_NEG = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    // What one slot of the narrowing chain does
    typedef enum logic [1:0] {
        OP_SLAB,
        OP_CHECK,
        OP_PASS
    } slot_op_t;

    // Per-item context that travels beside the dividers
    typedef struct packed {
        axis_t                 ax_max;
        axis_t                 ax_mid;
        axis_t                 ax_min;
        logic [NUM_AXES-1:0]   in_box;
        logic [NUM_AXES-1:0]   dzero;
        logic                  mid_par;
        logic                  min_par;
    } ctx_t;

    typedef struct packed {
        slot_op_t                   op;
        logic                       chk;
        logic signed [COORD_W-1:0]  tn;
        logic signed [COORD_W-1:0]  tf;
    } slot_t;

    typedef struct packed {
        logic                       ok;
        logic signed [COORD_W-1:0]  s;
        logic signed [COORD_W-1:0]  e;
    } iv_t;

    // Saturate a sign/magnitude quotient to a signed 32-bit distance
    function automatic logic signed [COORD_W-1:0] sat_q(
        input logic [QBITS-1:0] q,
        input logic             ovf,
        input logic             neg
    );
        logic signed [COORD_W-1:0] r;
        if (!neg) begin
            if (ovf || (q > QBITS'(T_INF)))
                r = T_INF;
            else
                r = q[COORD_W-1:0];
        end else begin
            if (ovf || (q > {1'b0, T_NEG}))
                r = T_NEG;
            else
                r = -q[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/ray_aabb_slab_interval.sv =====
// ----------------------------------------------------------------------------
// ray_aabb_slab_interval
// Ray versus axis-aligned box slab test with entry and exit distances.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word: box min and max
//   corners plus ray origin and direction, signed Q16.16. Output channel
//   (out_valid/out_ready) returns hit, t_enter and t_exit for each word,
//   in order. cfg_valid/cfg_ready writes parallel_threshold; cfg_ready is
//   always high. Write it only while the pipeline is empty.
//   Pipeline: 38 register stages (1 prep stage, 33 divider stages at one
//   quotient bit each, 1 saturation stage and one narrowing stage per
//   axis). Throughput: one word per cycle while the receiver does not
//   stall; the 33-stage divider lanes, six in parallel, set the depth.
//   Reset clears all valid bits and sets parallel_threshold to 1.
//   When the receiver stalls, the whole pipeline holds and in_ready drops;
//   nothing is lost or repeated. Empty slots are not squeezed out.
// ----------------------------------------------------------------------------
module ray_aabb_slab_interval
    import rasi_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [THR_W-1:0]           cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [COORD_W-1:0]  box_min_x,
    input  logic signed [COORD_W-1:0]  box_min_y,
    input  logic signed [COORD_W-1:0]  box_min_z,
    input  logic signed [COORD_W-1:0]  box_max_x,
    input  logic signed [COORD_W-1:0]  box_max_y,
    input  logic signed [COORD_W-1:0]  box_max_z,
    input  logic signed [COORD_W-1:0]  ray_origin_x,
    input  logic signed [COORD_W-1:0]  ray_origin_y,
    input  logic signed [COORD_W-1:0]  ray_origin_z,
    input  logic signed [COORD_W-1:0]  ray_dir_x,
    input  logic signed [COORD_W-1:0]  ray_dir_y,
    input  logic signed [COORD_W-1:0]  ray_dir_z,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       hit,
    output logic [T_W-1:0]             t_enter,
    output logic [T_W-1:0]             t_exit
);

    logic              en;
    logic [THR_W-1:0]  thr_reg;
    logic              prep_v_reg;
    ctx_t              prep_ctx;
    logic [DIFF_W-1:0] prep_num [NUM_JOBS];
    logic [MAG_W-1:0]  prep_den [NUM_AXES];
    logic              prep_neg [NUM_JOBS];

    ctx_t              ctx_line_reg [DIV_STAGES];
    logic              vld_line_reg [DIV_STAGES];

    logic [QBITS-1:0]  dq   [NUM_JOBS];
    logic              dovf [NUM_JOBS];
    logic              dneg [NUM_JOBS];

    // Global advance: move when the output slot is empty or being taken
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    rasi_prep u_prep (
        .clk          (clk),
        .en           (en),
        .box_min_x    (box_min_x),
        .box_min_y    (box_min_y),
        .box_min_z    (box_min_z),
        .box_max_x    (box_max_x),
        .box_max_y    (box_max_y),
        .box_max_z    (box_max_z),
        .ray_origin_x (ray_origin_x),
        .ray_origin_y (ray_origin_y),
        .ray_origin_z (ray_origin_z),
        .ray_dir_x    (ray_dir_x),
        .ray_dir_y    (ray_dir_y),
        .ray_dir_z    (ray_dir_z),
        .thr          (thr_reg),
        .ctx          (prep_ctx),
        .num          (prep_num),
        .den          (prep_den),
        .neg          (prep_neg)
    );

    // Six divider lanes: lo and hi bound of each axis
    for (genvar j = 0; j < NUM_JOBS; j++)
    begin : g_lane
        rasi_div u_div (
            .clk   (clk),
            .en    (en),
            .num   (prep_num[j]),
            .den   (prep_den[j/2]),
            .neg   (prep_neg[j]),
            .q     (dq[j]),
            .ovf   (dovf[j]),
            .q_neg (dneg[j])
        );
    end

    // Valid bits beside prep and the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_v_reg <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++)
                vld_line_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            prep_v_reg      <= in_valid;
            vld_line_reg[0] <= prep_v_reg;
            for (int k = 1; k < DIV_STAGES; k++)
                vld_line_reg[k] <= vld_line_reg[k-1];
        end
    end

    // Context delay line matching divider depth
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_line_reg[0] <= prep_ctx;
            for (int k = 1; k < DIV_STAGES; k++)
                ctx_line_reg[k] <= ctx_line_reg[k-1];
        end
    end

    rasi_slab u_slab (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vin     (vld_line_reg[DIV_STAGES-1]),
        .ctx     (ctx_line_reg[DIV_STAGES-1]),
        .q       (dq),
        .ovf     (dovf),
        .q_neg   (dneg),
        .vout    (out_valid),
        .hit     (hit),
        .t_enter (t_enter),
        .t_exit  (t_exit)
    );

    // A miss carries zero distances
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (t_enter == '0 && t_exit == '0))
        else $error("miss with nonzero distance");

    // A hit interval is never inverted
    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (t_enter <= t_exit))
        else $error("entry beyond exit");

    // A held result blocks new input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken during output stall");

    // Pipeline holds out_valid, hit and t_exit across a stall
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(t_exit) && $stable(hit)))
        else $error("output changed during stall");

endmodule

// ===== src/rasi_prep.sv =====
// ----------------------------------------------------------------------------
// rasi_prep
// Input stage: slab offsets, magnitudes, signs, axis order and flag bits.
// ----------------------------------------------------------------------------
module rasi_prep
    import rasi_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [COORD_W-1:0]  box_min_x,
    input  logic signed [COORD_W-1:0]  box_min_y,
    input  logic signed [COORD_W-1:0]  box_min_z,
    input  logic signed [COORD_W-1:0]  box_max_x,
    input  logic signed [COORD_W-1:0]  box_max_y,
    input  logic signed [COORD_W-1:0]  box_max_z,
    input  logic signed [COORD_W-1:0]  ray_origin_x,
    input  logic signed [COORD_W-1:0]  ray_origin_y,
    input  logic signed [COORD_W-1:0]  ray_origin_z,
    input  logic signed [COORD_W-1:0]  ray_dir_x,
    input  logic signed [COORD_W-1:0]  ray_dir_y,
    input  logic signed [COORD_W-1:0]  ray_dir_z,
    input  logic [THR_W-1:0]           thr,
    output ctx_t                       ctx,
    output logic [DIFF_W-1:0]          num [NUM_JOBS],
    output logic [MAG_W-1:0]           den [NUM_AXES],
    output logic                       neg [NUM_JOBS]
);

    logic signed [COORD_W-1:0] lo  [NUM_AXES];
    logic signed [COORD_W-1:0] hi  [NUM_AXES];
    logic signed [COORD_W-1:0] org [NUM_AXES];
    logic signed [COORD_W-1:0] dir [NUM_AXES];
    logic signed [DIFF_W-1:0]  dlo [NUM_AXES];
    logic signed [DIFF_W-1:0]  dhi [NUM_AXES];
    logic [MAG_W-1:0]          ad  [NUM_AXES];

    logic [DIFF_W-1:0] num_next [NUM_JOBS];
    logic              neg_next [NUM_JOBS];
    ctx_t              ctx_next;

    logic [DIFF_W-1:0] num_reg [NUM_JOBS];
    logic              neg_reg [NUM_JOBS];
    logic [MAG_W-1:0]  den_reg [NUM_AXES];
    ctx_t              ctx_reg;

    axis_t ax_max, ax_mid, ax_min;

    assign lo[0]  = box_min_x;
    assign lo[1]  = box_min_y;
    assign lo[2]  = box_min_z;
    assign hi[0]  = box_max_x;
    assign hi[1]  = box_max_y;
    assign hi[2]  = box_max_z;
    assign org[0] = ray_origin_x;
    assign org[1] = ray_origin_y;
    assign org[2] = ray_origin_z;
    assign dir[0] = ray_dir_x;
    assign dir[1] = ray_dir_y;
    assign dir[2] = ray_dir_z;

    // Offsets to both bounds, in sign/magnitude for the dividers
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            dlo[a] = DIFF_W'(lo[a]) - DIFF_W'(org[a]);
            dhi[a] = DIFF_W'(hi[a]) - DIFF_W'(org[a]);
            ad[a]  = dir[a][COORD_W-1] ? MAG_W'(-dir[a]) : MAG_W'(dir[a]);
            num_next[2*a]   = dlo[a][DIFF_W-1] ? DIFF_W'(-dlo[a]) : DIFF_W'(dlo[a]);
            num_next[2*a+1] = dhi[a][DIFF_W-1] ? DIFF_W'(-dhi[a]) : DIFF_W'(dhi[a]);
            neg_next[2*a]   = dlo[a][DIFF_W-1] ^ dir[a][COORD_W-1];
            neg_next[2*a+1] = dhi[a][DIFF_W-1] ^ dir[a][COORD_W-1];
        end
    end

    // Axis order by |dir|, largest first
    always_comb
    begin
        ax_max = AXIS_X;
        ax_mid = AXIS_Y;
        ax_min = AXIS_Z;
        if (ad[0] < ad[2])
        begin
            ax_max = AXIS_Z;
            ax_min = AXIS_X;
        end
        if (ad[1] < ad[ax_min])
        begin
            ax_mid = ax_min;
            ax_min = AXIS_Y;
        end
        else if (ad[1] > ad[ax_max])
        begin
            ax_mid = ax_max;
            ax_max = AXIS_Y;
        end
    end

    always_comb
    begin
        ctx_next.ax_max  = ax_max;
        ctx_next.ax_mid  = ax_mid;
        ctx_next.ax_min  = ax_min;
        ctx_next.mid_par = ad[ax_mid] < MAG_W'(thr);
        ctx_next.min_par = ad[ax_min] < MAG_W'(thr);
        for (int a = 0; a < NUM_AXES; a++)
        begin
            ctx_next.in_box[a] = !((org[a] < lo[a]) || (org[a] > hi[a]));
            ctx_next.dzero[a]  = (dir[a] == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg <= ctx_next;
            for (int j = 0; j < NUM_JOBS; j++)
            begin
                num_reg[j] <= num_next[j];
                neg_reg[j] <= neg_next[j];
            end
            for (int a = 0; a < NUM_AXES; a++)
                den_reg[a] <= ad[a];
        end
    end

    assign ctx = ctx_reg;
    assign num = num_reg;
    assign neg = neg_reg;
    assign den = den_reg;

endmodule

// ===== src/rasi_div.sv =====
// ----------------------------------------------------------------------------
// rasi_div
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit
// per stage, with an overflow flag for quotients beyond QBITS bits.
// ----------------------------------------------------------------------------
module rasi_div
    import rasi_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [DIFF_W-1:0]  num,
    input  logic [MAG_W-1:0]   den,
    input  logic               neg,
    output logic [QBITS-1:0]   q,
    output logic               ovf,
    output logic               q_neg
);

    logic [MAG_W-1:0]   r_init;
    logic               ovf_init;

    logic [MAG_W-1:0]   r_reg   [DIV_STAGES];
    logic [QBITS-1:0]   q_reg   [DIV_STAGES];
    logic [DIFF_W-1:0]  n_reg   [DIV_STAGES];
    logic [MAG_W-1:0]   d_reg   [DIV_STAGES];
    logic               o_reg   [DIV_STAGES];
    logic               g_reg   [DIV_STAGES];

    // Upper dividend bits form the first partial remainder
    assign r_init   = MAG_W'(num >> (QBITS - FRAC_BITS));
    assign ovf_init = (r_init >= den);

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_step
        localparam int BI = QBITS - 1 - k;

        logic [MAG_W-1:0]  cur_r;
        logic [QBITS-1:0]  cur_q;
        logic [DIFF_W-1:0] cur_n;
        logic [MAG_W-1:0]  cur_d;
        logic              cur_o;
        logic              cur_g;
        logic              dbit;
        logic [MAG_W:0]    trial;
        logic [MAG_W:0]    sub;
        logic              ge;
        logic [MAG_W-1:0]  r_next;
        logic [QBITS-1:0]  q_next;

        if (k == 0)
        begin : g_first
            assign cur_r = r_init;
            assign cur_q = '0;
            assign cur_n = num;
            assign cur_d = den;
            assign cur_o = ovf_init;
            assign cur_g = neg;
        end
        else
        begin : g_next
            assign cur_r = r_reg[k-1];
            assign cur_q = q_reg[k-1];
            assign cur_n = n_reg[k-1];
            assign cur_d = d_reg[k-1];
            assign cur_o = o_reg[k-1];
            assign cur_g = g_reg[k-1];
        end

        // Next dividend bit; the fraction shift supplies zeros
        if (BI >= FRAC_BITS)
        begin : g_nbit
            assign dbit = cur_n[BI-FRAC_BITS];
        end
        else
        begin : g_zbit
            assign dbit = 1'b0;
        end

        // Compare and subtract
        always_comb
        begin
            trial  = {cur_r, dbit};
            sub    = trial - {1'b0, cur_d};
            ge     = (trial >= {1'b0, cur_d});
            r_next = ge ? sub[MAG_W-1:0] : trial[MAG_W-1:0];
            q_next = cur_q;
            q_next[BI] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k] <= r_next;
                q_reg[k] <= q_next;
                n_reg[k] <= cur_n;
                d_reg[k] <= cur_d;
                o_reg[k] <= cur_o;
                g_reg[k] <= cur_g;
            end
        end
    end

    assign q     = q_reg[DIV_STAGES-1];
    assign ovf   = o_reg[DIV_STAGES-1];
    assign q_neg = g_reg[DIV_STAGES-1];

endmodule

// ===== src/rasi_slab.sv =====
// ----------------------------------------------------------------------------
// rasi_slab
// Saturates slab distances, orders them by axis, and narrows the interval
// over three stages, one axis each.
// ----------------------------------------------------------------------------
module rasi_slab
    import rasi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vin,
    input  ctx_t                ctx,
    input  logic [QBITS-1:0]    q     [NUM_JOBS],
    input  logic                ovf   [NUM_JOBS],
    input  logic                q_neg [NUM_JOBS],
    output logic                vout,
    output logic                hit,
    output logic [T_W-1:0]      t_enter,
    output logic [T_W-1:0]      t_exit
);

    localparam iv_t IV_INIT = '{ok: 1'b1, s: '0, e: T_INF};

    logic signed [COORD_W-1:0] t_lo [NUM_AXES];
    logic signed [COORD_W-1:0] t_hi [NUM_AXES];
    logic signed [COORD_W-1:0] tn   [NUM_AXES];
    logic signed [COORD_W-1:0] tf   [NUM_AXES];
    slot_t                     slot_next [NUM_AXES];

    slot_t slot_reg [NUM_AXES];
    slot_t mid_reg, min1_reg, min2_reg;
    iv_t   iv_reg [NUM_AXES];
    iv_t   iv_next [NUM_AXES];
    logic  v_reg [NUM_AXES+1];

    // One axis of narrowing
    function automatic iv_t narrow(input iv_t iv, input slot_t sl);
        iv_t r;
        r = iv;
        if (iv.ok)
        begin
            unique case (sl.op)
                OP_SLAB:
                begin
                    if ((sl.tn > iv.e) || (sl.tf < iv.s))
                        r.ok = 1'b0;
                    else
                    begin
                        if (sl.tn > iv.s)
                            r.s = sl.tn;
                        if (sl.tf < iv.e)
                            r.e = sl.tf;
                    end
                end
                OP_CHECK: r.ok = sl.chk;
                OP_PASS:  r = iv;
                default:  r = iv;
            endcase
        end
        return r;
    endfunction

    // Saturate and order near and far per axis
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            t_lo[a] = sat_q(q[2*a], ovf[2*a], q_neg[2*a]);
            t_hi[a] = sat_q(q[2*a+1], ovf[2*a+1], q_neg[2*a+1]);
            tn[a]   = (t_lo[a] > t_hi[a]) ? t_hi[a] : t_lo[a];
            tf[a]   = (t_lo[a] > t_hi[a]) ? t_lo[a] : t_hi[a];
        end
    end

    // Largest axis: a slab, or only a bounds check for a zero direction
    always_comb
    begin
        slot_next[0].tn  = tn[ctx.ax_max];
        slot_next[0].tf  = tf[ctx.ax_max];
        slot_next[0].chk = ctx.in_box[ctx.ax_max];
        slot_next[0].op  = ctx.dzero[ctx.ax_max] ? OP_CHECK : OP_SLAB;

        slot_next[1].tn = tn[ctx.ax_mid];
        slot_next[1].tf = tf[ctx.ax_mid];
        if (ctx.mid_par)
        begin
            // parallel middle axis: bounds check on both remaining axes
            slot_next[1].op  = OP_CHECK;
            slot_next[1].chk = ctx.in_box[ctx.ax_mid] & ctx.in_box[ctx.ax_min];
        end
        else
        begin
            slot_next[1].op  = ctx.dzero[ctx.ax_mid] ? OP_CHECK : OP_SLAB;
            slot_next[1].chk = ctx.in_box[ctx.ax_mid];
        end

        slot_next[2].tn  = tn[ctx.ax_min];
        slot_next[2].tf  = tf[ctx.ax_min];
        slot_next[2].chk = ctx.in_box[ctx.ax_min];
        priority if (ctx.mid_par)
            slot_next[2].op = OP_PASS;
        else if (ctx.min_par || ctx.dzero[ctx.ax_min])
            slot_next[2].op = OP_CHECK;
        else
            slot_next[2].op = OP_SLAB;
    end

    always_comb
    begin
        iv_next[0] = narrow(IV_INIT, slot_reg[0]);
        iv_next[1] = narrow(iv_reg[0], mid_reg);
        iv_next[2] = narrow(iv_reg[1], min2_reg);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NUM_AXES; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= vin;
            for (int i = 1; i <= NUM_AXES; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                slot_reg[a] <= slot_next[a];
                iv_reg[a]   <= iv_next[a];
            end
            mid_reg  <= slot_reg[1];
            min1_reg <= slot_reg[2];
            min2_reg <= min1_reg;
        end
    end

    assign vout    = v_reg[NUM_AXES];
    assign hit     = iv_reg[2].ok;
    assign t_enter = iv_reg[2].ok ? iv_reg[2].s[T_W-1:0] : '0;
    assign t_exit  = iv_reg[2].ok ? iv_reg[2].e[T_W-1:0] : '0;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ray versus box slab test. A directed table
// covers extremes, parallel axes, zero directions and inverted boxes; random
// rays and boxes follow under several threshold settings. Each result word
// is compared with a table result or a behavioral prediction queued at input acceptance.
// ----------------------------------------------------------------------------
module tb_top;
    import rasi_pkg::*;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct {
        coord_t mn[3];
        coord_t mx[3];
        coord_t org[3];
        coord_t dir[3];
    } ray_box_t;

    typedef struct {
        logic           hit;
        logic [T_W-1:0] t_enter;
        logic [T_W-1:0] t_exit;
    } slab_result_t;

    typedef struct {
        ray_box_t     rb;
        logic         known;
        slab_result_t res;
    } table_row_t;

    localparam int DRAIN_CYCLES = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [THR_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    coord_t box_min_x = '0, box_min_y = '0, box_min_z = '0;
    coord_t box_max_x = '0, box_max_y = '0, box_max_z = '0;
    coord_t ray_origin_x = '0, ray_origin_y = '0, ray_origin_z = '0;
    coord_t ray_dir_x = '0, ray_dir_y = '0, ray_dir_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit;
    logic [T_W-1:0] t_enter;
    logic [T_W-1:0] t_exit;

    logic [THR_W-1:0] thr_model;
    slab_result_t     pending_hits[$];
    int               mismatch_count = 0;
    bit               stim_done = 1'b0;

    ray_aabb_slab_interval DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
        .box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
        .ray_origin_x(ray_origin_x), .ray_origin_y(ray_origin_y),
        .ray_origin_z(ray_origin_z),
        .ray_dir_x(ray_dir_x), .ray_dir_y(ray_dir_y), .ray_dir_z(ray_dir_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .t_enter(t_enter), .t_exit(t_exit)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Quotient of one slab bound, saturated to 32 bits
    function automatic longint slab_div(longint num, longint den);
        longint q;
        q = (num * 65536) / den;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q;
    endfunction

    function automatic bit origin_in(longint lo, longint hi, longint o);
        return !(o < lo || o > hi);
    endfunction

    // Narrow [s,e] by one axis slab; 0 on a miss
    function automatic bit narrow(longint lo, longint hi, longint o, longint d,
                                  inout longint s, inout longint e);
        longint tn, tf, tmp;
        if (d == 0)
            return origin_in(lo, hi, o);
        tn = slab_div(lo - o, d);
        tf = slab_div(hi - o, d);
        if (tn > tf)
        begin
            tmp = tn; tn = tf; tf = tmp;
        end
        if (tn > e || tf < s)
            return 1'b0;
        if (tn > s)
            s = tn;
        if (tf < e)
            e = tf;
        return 1'b1;
    endfunction

    function automatic slab_result_t predict_interval(ray_box_t rb,
                                                      logic [THR_W-1:0] thr);
        longint mn[3], mx[3], og[3], dr[3], ad[3];
        longint s, e;
        int ia, ib, ic;
        bit ok;
        slab_result_t r;
        for (int i = 0; i < 3; i++)
        begin
            mn[i] = rb.mn[i]; mx[i] = rb.mx[i];
            og[i] = rb.org[i]; dr[i] = rb.dir[i];
            ad[i] = dr[i] < 0 ? -dr[i] : dr[i];
        end
        // ia: largest, ib: middle, ic: smallest
        ia = 0; ib = 1; ic = 2;
        if (ad[0] < ad[2])
        begin
            ia = 2; ic = 0;
        end
        if (ad[1] < ad[ic])
        begin
            ib = ic; ic = 1;
        end
        else if (ad[1] > ad[ia])
        begin
            ib = ia; ia = 1;
        end
        s = 0;
        e = 64'sd2147483647;
        ok = narrow(mn[ia], mx[ia], og[ia], dr[ia], s, e);
        if (ok)
        begin
            if (ad[ib] < longint'(thr))
                ok = origin_in(mn[ib], mx[ib], og[ib]) && origin_in(mn[ic], mx[ic], og[ic]);
            else
            begin
                ok = narrow(mn[ib], mx[ib], og[ib], dr[ib], s, e);
                if (ok)
                begin
                    if (ad[ic] < longint'(thr))
                        ok = origin_in(mn[ic], mx[ic], og[ic]);
                    else
                        ok = narrow(mn[ic], mx[ic], og[ic], dr[ic], s, e);
                end
            end
        end
        r.hit = ok;
        r.t_enter = ok ? T_W'(s) : '0;
        r.t_exit = ok ? T_W'(e) : '0;
        return r;
    endfunction

    // Random coordinate: mostly small values, some full range and edges
    function automatic coord_t rand_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return coord_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        else if (k < 8)
            return coord_t'($urandom);
        else if (k == 8)
            return $urandom_range(0, 1) ? T_INF : T_NEG;
        return coord_t'($signed($urandom_range(0, 6)) - 3);
    endfunction

    function automatic ray_box_t rand_ray_box();
        ray_box_t rb;
        coord_t a, b;
        for (int i = 0; i < 3; i++)
        begin
            a = rand_coord();
            b = rand_coord();
            // mostly well-formed boxes, some inverted
            if ($urandom_range(0, 9) != 0 && a > b)
            begin
                rb.mn[i] = b; rb.mx[i] = a;
            end
            else
            begin
                rb.mn[i] = a; rb.mx[i] = b;
            end
            rb.org[i] = rand_coord();
            rb.dir[i] = rand_coord();
        end
        return rb;
    endfunction

    function automatic ray_box_t make_rb(coord_t lo, coord_t hi, coord_t o,
                                         coord_t dx, coord_t dy, coord_t dz);
        ray_box_t rb;
        for (int i = 0; i < 3; i++)
        begin
            rb.mn[i] = lo; rb.mx[i] = hi; rb.org[i] = o;
        end
        rb.dir[0] = dx; rb.dir[1] = dy; rb.dir[2] = dz;
        return rb;
    endfunction

    // Idle gap before the next word; valid drops only when a gap is taken
    task automatic idle_gap();
        int k;
        k = $urandom_range(0, 19);
        if (k < 10)
            return;
        in_valid <= 1'b0;
        if (k < 18)
            repeat ($urandom_range(1, 3)) @(negedge clk);
        else
            repeat ($urandom_range(10, 40)) @(negedge clk);
    endtask

    // Send one word at a falling edge; returns at the falling edge after
    // acceptance with valid still high, so words can follow back to back
    task automatic send_word(ray_box_t rb, logic known, slab_result_t res);
        slab_result_t exp_res;
        box_min_x <= rb.mn[0]; box_min_y <= rb.mn[1]; box_min_z <= rb.mn[2];
        box_max_x <= rb.mx[0]; box_max_y <= rb.mx[1]; box_max_z <= rb.mx[2];
        ray_origin_x <= rb.org[0]; ray_origin_y <= rb.org[1];
        ray_origin_z <= rb.org[2];
        ray_dir_x <= rb.dir[0]; ray_dir_y <= rb.dir[1]; ray_dir_z <= rb.dir[2];
        in_valid <= 1'b1;
        exp_res = known ? res : predict_interval(rb, thr_model);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_hits.push_back(exp_res);
        @(negedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        in_valid <= 1'b0;
        // pipeline must be empty before the write
        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        thr_model = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        slab_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hits.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word hit=%0d enter=%h exit=%h",
                             hit, t_enter, t_exit);
            end
            else
            begin
                want = pending_hits.pop_front();
                if (hit !== want.hit || t_enter !== want.t_enter ||
                    t_exit !== want.t_exit)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp hit=%0d enter=%h exit=%h, ",
                                  "got hit=%0d enter=%h exit=%h"},
                                 want.hit, want.t_enter, want.t_exit,
                                 hit, t_enter, t_exit);
                end
            end
        end
    end

    // Receiver stalls
    initial
    begin
        int k;
        forever
        begin
            @(negedge clk);
            k = $urandom_range(0, 19);
            if (k < 12)
                out_ready <= 1'b1;
            else if (k < 19)
                out_ready <= 1'b0;
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge clk);
            end
        end
    end

    // Stimulus
    initial
    begin
        table_row_t rows[$];
        table_row_t row;
        slab_result_t miss;
        logic [THR_W-1:0] thr_set[5];
        miss = '{1'b0, '0, '0};
        thr_model = THR_RESET;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        // origin inside unit box, all directions zero: unbounded interval
        rows.push_back('{make_rb(-65536, 65536, 0, 0, 0, 0), 1'b1,
                         '{1'b1, '0, T_W'(T_INF)}});
        // origin outside, all directions zero: miss
        rows.push_back('{make_rb(65536, 131072, 0, 0, 0, 0), 1'b1, miss});
        // inverted box, zero direction: miss
        rows.push_back('{make_rb(65536, -65536, 0, 0, 0, 0), 1'b1, miss});
        // along x from outside; y and z origins outside with zero direction: miss
        row.rb = make_rb(65536, 131072, 65536 * 2 - 65536 * 4, 65536, 0, 0);
        row.known = 1'b0; rows.push_back(row);
        row.rb = make_rb(-65536, 65536, 0, 65536, 65536, 65536); rows.push_back(row);
        row.rb = make_rb(-65536, 65536, 0, -65536, 32768, -1); rows.push_back(row);
        // tiny direction: saturated division
        row.rb = make_rb(T_NEG, T_INF, 0, 1, 1, 1); rows.push_back(row);
        row.rb = make_rb(T_NEG, T_INF, T_INF, T_NEG, T_NEG, T_NEG); rows.push_back(row);
        row.rb = make_rb(T_NEG, T_INF, T_NEG, T_INF, -1, 1); rows.push_back(row);
        row.rb = make_rb(T_INF, T_INF, T_NEG, T_INF, T_INF, T_INF); rows.push_back(row);
        row.rb = make_rb(65536, 131072, 0, -65536, 65536, 0); rows.push_back(row);
        // axis ties, y largest, y smallest
        row.rb = make_rb(-65536, 65536, 0, 100, 200, 100); rows.push_back(row);
        row.rb = make_rb(-65536, 65536, 0, 300, 5, 200); rows.push_back(row);
        row.rb = make_rb(-65536, 65536, 0, 5, 300, 200); rows.push_back(row);
        row.rb = make_rb(-65536, 65536, 70000, 65536, 65536, 65536); rows.push_back(row);
        row.rb = make_rb(-1, -1, -1, -65536, -65536, -65536); rows.push_back(row);
        for (int i = 0; i < rows.size(); i++)
            send_word(rows[i].rb, rows[i].known, rows[i].res);

        // Random phases across threshold settings, extremes included
        thr_set = '{17'd0, 17'd65536, 17'd1, 17'd300, 17'd1 << 14};
        for (int p = 0; p < 5; p++)
        begin
            write_threshold(thr_set[p]);
            for (int n = 0; n < 230; n++)
            begin
                idle_gap();
                send_word(rand_ray_box(), 1'b0, miss);
            end
        end

        in_valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        stim_done = 1'b1;
    end

    // Final verdict
    initial
    begin
        wait (stim_done);
        if (mismatch_count == 0 && pending_hits.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Timeout
    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule
